>>> sv/nflsched_pkg.sv
package nflsched_pkg;

  localparam int unsigned MAX_JOBS = 32;
  localparam int unsigned IDX_W    = $clog2(MAX_JOBS);
  localparam int unsigned CNT_W    = $clog2(MAX_JOBS + 1);

  localparam int unsigned ID_W   = 10;
  localparam int unsigned HALF_W = 16;
  localparam int unsigned TIME_W = 23;
  localparam int unsigned JOB_W  = ID_W + 2 * HALF_W;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 136;

  localparam logic POL_FCFS = 1'b0;
  localparam logic POL_LCFS = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // write the incoming job
    logic idx_clr;    // index back to zero
    logic idx_inc;    // index step
    logic scan;       // issue a table read for the lcfs scan
    logic fcfs_run;   // start the job at the index
    logic lcfs_pick;  // start the chosen job
    logic out_load;   // fill the result register
    logic clear;      // empty the set
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic policy;
    logic idx_last;
    logic sched_last;
    logic out_free;
    logic count_nz;
  } dp_stat_t;

endpackage

>>> sv/nflsched_ram.sv
module nflsched_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/nflsched_dp.sv
module nflsched_dp
  import nflsched_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_stat_t          stat_o,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic [ID_W-1:0]   in_id_i,
  input  logic [HALF_W-1:0] in_arr_i,
  input  logic [HALF_W-1:0] in_len_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ID_W-1:0]   out_id_o,
  output logic [HALF_W-1:0] out_arr_o,
  output logic [HALF_W-1:0] out_len_o,
  output logic [TIME_W-1:0] out_start_o,
  output logic [TIME_W-1:0] out_finish_o,
  output logic [TIME_W-1:0] out_wait_o,
  output logic [TIME_W-1:0] out_turn_o,
  output logic              out_last_o
);

  logic                policy_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    sched_q, sched_d;
  logic [TIME_W-1:0]   clock_q, clock_d;
  logic [MAX_JOBS-1:0] done_q, done_d;
  logic                chk_q;
  logic [IDX_W-1:0]    chk_idx_q;

  logic                best_found_q, best_found_d;
  logic [IDX_W-1:0]    best_idx_q, best_idx_d;
  logic [HALF_W-1:0]   best_arr_q, best_arr_d;
  logic [HALF_W-1:0]   best_len_q, best_len_d;
  logic                first_found_q, first_found_d;
  logic [IDX_W-1:0]    first_idx_q, first_idx_d;
  logic [HALF_W-1:0]   first_arr_q, first_arr_d;
  logic [HALF_W-1:0]   first_len_q, first_len_d;

  logic                out_valid_q;
  logic [ID_W-1:0]     out_id_q;
  logic [HALF_W-1:0]   out_arr_q, out_len_q;
  logic [TIME_W-1:0]   out_start_q, out_finish_q, out_wait_q, out_turn_q;
  logic                out_last_q;

  logic [JOB_W-1:0]    job_rd;
  logic [TIME_W-1:0]   st_rd;
  logic [ID_W-1:0]     rd_id;
  logic [HALF_W-1:0]   rd_arr, rd_len;
  logic [TIME_W-1:0]   rd_arr_t;
  logic                table_open;
  logic                idx_last;

  logic [TIME_W-1:0]   fcfs_start;
  logic [IDX_W-1:0]    pick_idx;
  logic [HALF_W-1:0]   pick_len;
  logic [TIME_W-1:0]   pick_start;
  logic [TIME_W-1:0]   run_start;
  logic [HALF_W-1:0]   run_len;
  logic [IDX_W-1:0]    st_waddr;
  logic                st_we;

  logic                chk_undone, take_best, take_first;
  logic [TIME_W-1:0]   res_fin;

  assign table_open = count_q < CNT_W'(MAX_JOBS);
  assign idx_last   = CNT_W'(idx_q) == (count_q - CNT_W'(1));

  nflsched_ram #(
    .WIDTH(JOB_W),
    .DEPTH(MAX_JOBS)
  ) u_job_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load && table_open),
    .waddr_i(count_q[IDX_W-1:0]),
    .wdata_i({in_len_i, in_arr_i, in_id_i}),
    .raddr_i(idx_q),
    .rdata_o(job_rd)
  );

  nflsched_ram #(
    .WIDTH(TIME_W),
    .DEPTH(MAX_JOBS)
  ) u_start_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(run_start),
    .raddr_i(idx_q),
    .rdata_o(st_rd)
  );

  assign rd_id    = job_rd[ID_W-1:0];
  assign rd_arr   = job_rd[ID_W +: HALF_W];
  assign rd_len   = job_rd[ID_W+HALF_W +: HALF_W];
  assign rd_arr_t = {{(TIME_W-HALF_W){1'b0}}, rd_arr};

  // fcfs: the job starts at the later of clock and arrival
  assign fcfs_start = (clock_q < rd_arr_t) ? rd_arr_t : clock_q;

  // lcfs: nothing arrived yet means the clock jumps to the first undone job
  assign pick_idx   = best_found_q ? best_idx_q : first_idx_q;
  assign pick_len   = best_found_q ? best_len_q : first_len_q;
  assign pick_start = best_found_q ? clock_q : {{(TIME_W-HALF_W){1'b0}}, first_arr_q};

  assign run_start = cmd_i.fcfs_run ? fcfs_start : pick_start;
  assign run_len   = cmd_i.fcfs_run ? rd_len : pick_len;
  assign st_we     = cmd_i.fcfs_run || cmd_i.lcfs_pick;
  assign st_waddr  = cmd_i.fcfs_run ? idx_q : pick_idx;

  // ties keep the earlier entry since the compare is strict
  assign chk_undone = !done_q[chk_idx_q];
  assign take_best  = chk_q && chk_undone && (rd_arr_t <= clock_q) &&
                      (!best_found_q || (rd_arr > best_arr_q));
  assign take_first = chk_q && chk_undone && !first_found_q;

  assign res_fin = st_rd + TIME_W'(rd_len);

  always_comb begin
    count_d       = count_q;
    idx_d         = idx_q;
    sched_d       = sched_q;
    clock_d       = clock_q;
    done_d        = done_q;
    best_found_d  = best_found_q;
    best_idx_d    = best_idx_q;
    best_arr_d    = best_arr_q;
    best_len_d    = best_len_q;
    first_found_d = first_found_q;
    first_idx_d   = first_idx_q;
    first_arr_d   = first_arr_q;
    first_len_d   = first_len_q;

    if (cmd_i.load && table_open) begin
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc || cmd_i.scan) begin
      idx_d = idx_q + IDX_W'(1);
    end
    if (take_best) begin
      best_found_d = 1'b1;
      best_idx_d   = chk_idx_q;
      best_arr_d   = rd_arr;
      best_len_d   = rd_len;
    end
    if (take_first) begin
      first_found_d = 1'b1;
      first_idx_d   = chk_idx_q;
      first_arr_d   = rd_arr;
      first_len_d   = rd_len;
    end
    if (st_we) begin
      clock_d = run_start + TIME_W'(run_len);
    end
    if (cmd_i.lcfs_pick) begin
      done_d[pick_idx] = 1'b1;
      sched_d          = sched_q + CNT_W'(1);
      best_found_d     = 1'b0;
      first_found_d    = 1'b0;
    end
    if (cmd_i.clear) begin
      count_d       = '0;
      idx_d         = '0;
      sched_d       = '0;
      clock_d       = '0;
      done_d        = '0;
      best_found_d  = 1'b0;
      first_found_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q      <= POL_FCFS;
      count_q       <= '0;
      idx_q         <= '0;
      sched_q       <= '0;
      clock_q       <= '0;
      done_q        <= '0;
      chk_q         <= 1'b0;
      best_found_q  <= 1'b0;
      first_found_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        policy_q <= cfg_wdata_i;
      end
      count_q       <= count_d;
      idx_q         <= idx_d;
      sched_q       <= sched_d;
      clock_q       <= clock_d;
      done_q        <= done_d;
      chk_q         <= cmd_i.scan;
      best_found_q  <= best_found_d;
      first_found_q <= first_found_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q   <= idx_q;
    best_idx_q  <= best_idx_d;
    best_arr_q  <= best_arr_d;
    best_len_q  <= best_len_d;
    first_idx_q <= first_idx_d;
    first_arr_q <= first_arr_d;
    first_len_q <= first_len_d;
    if (cmd_i.out_load) begin
      out_id_q     <= rd_id;
      out_arr_q    <= rd_arr;
      out_len_q    <= rd_len;
      out_start_q  <= st_rd;
      out_finish_q <= res_fin;
      out_wait_q   <= st_rd - rd_arr_t;
      out_turn_q   <= res_fin - rd_arr_t;
      out_last_q   <= idx_last;
    end
  end

  assign stat_o.policy     = policy_q;
  assign stat_o.idx_last   = idx_last;
  assign stat_o.sched_last = sched_q == (count_q - CNT_W'(1));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;
  assign stat_o.count_nz   = count_q != '0;

  assign out_valid_o  = out_valid_q;
  assign out_id_o     = out_id_q;
  assign out_arr_o    = out_arr_q;
  assign out_len_o    = out_len_q;
  assign out_start_o  = out_start_q;
  assign out_finish_o = out_finish_q;
  assign out_wait_o   = out_wait_q;
  assign out_turn_o   = out_turn_q;
  assign out_last_o   = out_last_q;

endmodule

>>> sv/nflsched_ctrl.sv
module nflsched_ctrl
  import nflsched_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_F_RD   = 3'd1;
  localparam logic [2:0] S_F_RUN  = 3'd2;
  localparam logic [2:0] S_L_SCAN = 3'd3;
  localparam logic [2:0] S_L_LAST = 3'd4;
  localparam logic [2:0] S_L_PICK = 3'd5;
  localparam logic [2:0] S_O_RD   = 3'd6;
  localparam logic [2:0] S_O_LD   = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.idx_clr = 1'b1;
            state_d = (stat_i.policy == POL_LCFS) ? S_L_SCAN : S_F_RD;
          end
        end
      end
      S_F_RD: begin
        state_d = S_F_RUN;
      end
      S_F_RUN: begin
        cmd_o.fcfs_run = 1'b1;
        if (stat_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          state_d = S_O_RD;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = S_F_RD;
        end
      end
      S_L_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.idx_last) begin
          state_d = S_L_LAST;
        end
      end
      // read data of the last entry is checked here
      S_L_LAST: begin
        state_d = S_L_PICK;
      end
      S_L_PICK: begin
        cmd_o.lcfs_pick = 1'b1;
        cmd_o.idx_clr   = 1'b1;
        state_d = stat_i.sched_last ? S_O_RD : S_L_SCAN;
      end
      S_O_RD: begin
        state_d = S_O_LD;
      end
      S_O_LD: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (stat_i.idx_last) begin
            cmd_o.clear = 1'b1;
            state_d = S_LOAD;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d = S_O_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/nonpreemptive_fcfs_lcfs_scheduler.sv
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  job id, arrival, run length; tlast = last job
// m_axis    out        m_axis_tvalid/m_axis_tready  job, start, finish, wait, turnaround; tlast
// cfg       in         cfg_we_i                     policy mode (0 fcfs, 1 lcfs)
//
// loading takes one request per cycle; the set is then scheduled, fcfs reading and starting
// each job in turn, lcfs bound by one table read port scanning all entries per pick
// results leave one at a time: a table read, then the output load, delayed by m_axis stalls
// s_axis_tready is low from the last job until the last result enters the output register
// async active-low reset clears control state; tables need no clearing pass
module nonpreemptive_fcfs_lcfs_scheduler
  import nflsched_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // job_id[9:0], arrival_time[25:10], run_length[41:26], zero fill
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // out_job_id[9:0], out_arrival[25:10], out_length[41:26], start_time[64:42],
  // finish_time[87:65], wait_time[110:88], turnaround_time[133:111], zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast
);

  localparam int unsigned OUT_USED_W = JOB_W + 4 * TIME_W;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic [ID_W-1:0]   out_id;
  logic [HALF_W-1:0] out_arr, out_len;
  logic [TIME_W-1:0] out_start, out_finish, out_wait, out_turn;

  nflsched_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_last_i (s_axis_tlast),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  nflsched_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_id_i     (s_axis_tdata[ID_W-1:0]),
    .in_arr_i    (s_axis_tdata[ID_W +: HALF_W]),
    .in_len_i    (s_axis_tdata[ID_W+HALF_W +: HALF_W]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_id_o    (out_id),
    .out_arr_o   (out_arr),
    .out_len_o   (out_len),
    .out_start_o (out_start),
    .out_finish_o(out_finish),
    .out_wait_o  (out_wait),
    .out_turn_o  (out_turn),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-OUT_USED_W){1'b0}}, out_turn, out_wait, out_finish,
                         out_start, out_len, out_arr, out_id};

  // a result only overwrites the output register once it has been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> stat.out_free)
    else $error("result register overwritten while full");

  // scheduling never starts on an empty set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> stat.count_nz)
    else $error("scheduling started with no jobs");

  // output valid only rises from a result load
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.out_load))
    else $error("output valid without a result load");

endmodule
